// ----- rtl/core/kabf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman angle and bias filter package
// Shared widths, register indexes, reset values and sequencer codes.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int FRAC = 28;
	localparam int CFG_W = 31;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_R_MEAS  = 2'd2;

	localparam logic [CFG_W-1:0] Q_ANGLE_RST = 31'd268435;
	localparam logic [CFG_W-1:0] Q_BIAS_RST  = 31'd0;
	localparam logic [CFG_W-1:0] R_MEAS_RST  = 31'd8053064;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CALC = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_DONE = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v, inout logic s);
		if (v > 66'sd2147483647) begin
			s = 1'b1;
			sat32 = 32'h7fffffff;
		end else if (v < -66'sd2147483648) begin
			s = 1'b1;
			sat32 = 32'h80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// ----- rtl/core/kalman_angle_bias_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman angle and bias filter
// Two-state tilt filter run by a sequencer over one shared multiplier
// and a restoring divider.
// ----------------------------------------------------------------------------
// Input words carry a channel, a measured angle, a gyro rate and a time step;
// each gives one output word with the filtered angle, the bias and a flag
// that is set when any intermediate value saturated or the innovation
// variance was zero. The block takes one word at a time: in_ready is high
// only while idle. An item runs the sequencer steps on the shared 32x32
// multiplier, plus two restoring divisions for the gains, one quotient bit
// per cycle. With a zero innovation variance the divisions are skipped.
// The result sits in an output register until taken; a stalled receiver
// holds the block, which then accepts no new word. Reset clears all channel
// state to zero and loads the noise registers with their defaults.
// Configuration writes are taken at any edge with cfg_we high; a zero
// written to the measurement noise is stored as one.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
	import kabf_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                axis,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  measured_rate,
	input  logic [30:0]         time_step,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  filtered_angle,
	output logic signed [31:0]  rate_bias,
	output logic                saturated
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q;
	logic [CFG_W-1:0] q_angle_q, q_bias_q, r_meas_q;
	logic [31:0] ang_q [CHANNELS];
	logic [31:0] bias_q [CHANNELS];
	logic [31:0] paa_q [CHANNELS];
	logic [31:0] pab_q [CHANNELS];
	logic [31:0] pba_q [CHANNELS];
	logic [31:0] pbb_q [CHANNELS];

	logic [CH_W-1:0] ch_q;
	logic [31:0] ma_q, mr_q, dt_q;
	logic [31:0] a_q, b_q, p00_q, p01_q, p10_q, p11_q, t_q, s_q, k0_q, k1_q, y_q;
	logic [31:0] p00o_q, p01o_q;
	logic [4:0] step_q;
	logic sat_q;

	logic signed [31:0] ma_in, mb_in;
	logic signed [63:0] prod_q;
	logic signed [31:0] mres;
	logic msat;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [5:0] dcnt_q;
	logic dneg_q;
	logic [63:0] rem_try;

	logic [CH_W-1:0] ch_in;
	assign ch_in = (CHANNELS > 1) ? CH_W'(axis) : '0;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= Q_ANGLE_RST;
			q_bias_q <= Q_BIAS_RST;
			r_meas_q <= R_MEAS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_Q_ANGLE: q_angle_q <= cfg_data;
				REG_Q_BIAS:  q_bias_q <= cfg_data;
				REG_R_MEAS:  r_meas_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				default: ;
			endcase
		end
	end

	// Operand select for the shared multiplier, by step.
	always_comb begin
		ma_in = dt_q;
		mb_in = t_q;
		case (step_q)
			5'd1:  mb_in = t_q;
			5'd3:  mb_in = p11_q;
			5'd6:  mb_in = t_q;
			5'd8:  begin ma_in = {1'b0, q_bias_q}; mb_in = dt_q; end
			5'd13: begin ma_in = k0_q; mb_in = y_q; end
			5'd14: begin ma_in = k1_q; mb_in = y_q; end
			5'd15: begin ma_in = k0_q; mb_in = p00o_q; end
			5'd16: begin ma_in = k0_q; mb_in = p01o_q; end
			5'd17: begin ma_in = k1_q; mb_in = p00o_q; end
			5'd18: begin ma_in = k1_q; mb_in = p01o_q; end
			default: ;
		endcase
	end

	always_comb begin
		logic signed [65:0] r;
		logic s;
		s = 1'b0;
		r = (66'(prod_q) + 66'sd134217728) >>> FRAC;
		mres = sat32(r, s);
		msat = s;
	end

	assign rem_try = {rem_q[62:0], quo_q[63]} - dvs_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) prod_q <= 64'(ma_in) * 64'(mb_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic s;
		logic [31:0] v;
		logic signed [65:0] sum;
		logic [63:0] qf;
		logic signed [65:0] qs;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			step_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ang_q[c] <= '0; bias_q[c] <= '0; paa_q[c] <= '0;
				pab_q[c] <= '0; pba_q[c] <= '0; pbb_q[c] <= '0;
			end
		end else begin
			s = sat_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ch_q <= ch_in;
						ma_q <= measured_angle;
						mr_q <= measured_rate;
						dt_q <= {1'b0, time_step};
						a_q <= ang_q[ch_in];
						b_q <= bias_q[ch_in];
						p00_q <= paa_q[ch_in];
						p01_q <= pab_q[ch_in];
						p10_q <= pba_q[ch_in];
						p11_q <= pbb_q[ch_in];
						s = 1'b0;
						step_q <= 5'd0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					// Adder and divider set-up steps; the other steps pass on to the multiplier.
					case (step_q)
						5'd0: begin
							t_q <= sat32(66'(signed'(mr_q)) - 66'(signed'(b_q)), s);
							step_q <= 5'd1; state_q <= ST_MUL;
						end
						5'd9: begin
							s_q <= sat32(66'(signed'(p00_q)) + 66'(r_meas_q), s);
							step_q <= 5'd10;
						end
						5'd10: begin
							if (s_q == '0) begin
								s = 1'b1; k0_q <= '0; k1_q <= '0; step_q <= 5'd12;
							end else begin
								dneg_q <= p00_q[31] ^ s_q[31];
								rem_q <= '0;
								quo_q <= {4'd0, (p00_q[31] ? -p00_q : p00_q), 28'd0};
								dvs_q <= {32'd0, (s_q[31] ? -s_q : s_q)};
								dcnt_q <= '0;
								state_q <= ST_DIV;
							end
						end
						5'd11: begin
							dneg_q <= p10_q[31] ^ s_q[31];
							rem_q <= '0;
							quo_q <= {4'd0, (p10_q[31] ? -p10_q : p10_q), 28'd0};
							dcnt_q <= '0;
							state_q <= ST_DIV;
						end
						5'd12: begin
							y_q <= sat32(66'(signed'(ma_q)) - 66'(signed'(a_q)), s);
							p00o_q <= p00_q; p01o_q <= p01_q;
							step_q <= 5'd13; state_q <= ST_MUL;
						end
						default: begin
							step_q <= step_q + 5'd1; state_q <= ST_MUL;
						end
					endcase
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					v = mres;
					s = s | msat;
					case (step_q)
						5'd1: begin
							a_q <= sat32(66'(signed'(a_q)) + 66'(signed'(v)), s);
							step_q <= 5'd2; state_q <= ST_CALC;
						end
						5'd3: begin
							sum = 66'(signed'(v)) - 66'(signed'(p01_q)) - 66'(signed'(p10_q))
								+ 66'(q_angle_q);
							t_q <= sat32(sum, s);
							p01_q <= sat32(66'(signed'(p01_q)) - 66'(signed'(v)), s);
							p10_q <= sat32(66'(signed'(p10_q)) - 66'(signed'(v)), s);
							step_q <= 5'd6; state_q <= ST_MUL;
						end
						5'd6: begin
							p00_q <= sat32(66'(signed'(p00_q)) + 66'(signed'(v)), s);
							step_q <= 5'd8; state_q <= ST_MUL;
						end
						5'd8: begin
							p11_q <= sat32(66'(signed'(p11_q)) + 66'(signed'(v)), s);
							step_q <= 5'd9; state_q <= ST_CALC;
						end
						5'd13: begin
							a_q <= sat32(66'(signed'(a_q)) + 66'(signed'(v)), s);
							step_q <= 5'd14; state_q <= ST_MUL;
						end
						5'd14: begin
							b_q <= sat32(66'(signed'(b_q)) + 66'(signed'(v)), s);
							step_q <= 5'd15; state_q <= ST_MUL;
						end
						5'd15: begin
							p00_q <= sat32(66'(signed'(p00_q)) - 66'(signed'(v)), s);
							step_q <= 5'd16; state_q <= ST_MUL;
						end
						5'd16: begin
							p01_q <= sat32(66'(signed'(p01_q)) - 66'(signed'(v)), s);
							step_q <= 5'd17; state_q <= ST_MUL;
						end
						5'd17: begin
							p10_q <= sat32(66'(signed'(p10_q)) - 66'(signed'(v)), s);
							step_q <= 5'd18; state_q <= ST_MUL;
						end
						default: begin
							p11_q <= sat32(66'(signed'(p11_q)) - 66'(signed'(v)), s);
							state_q <= ST_OUT;
							ang_q[ch_q] <= a_q;
							bias_q[ch_q] <= b_q;
							paa_q[ch_q] <= p00_q;
							pab_q[ch_q] <= p01_q;
							pba_q[ch_q] <= p10_q;
							pbb_q[ch_q] <= sat32(66'(signed'(p11_q)) - 66'(signed'(v)), s);
							filtered_angle <= a_q;
							rate_bias <= b_q;
							saturated <= s;
							out_valid <= 1'b1;
						end
					endcase
				end
				ST_DIV: begin
					// Restoring division, one quotient bit a cycle over 64 bits.
					if (!rem_try[63]) begin
						rem_q <= rem_try;
						qf = {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						qf = {quo_q[62:0], 1'b0};
					end
					quo_q <= qf;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						// Finish the quotient: sign and clip, then pick the gain slot.
						qs = dneg_q ? -66'(qf) : 66'(qf);
						v = sat32(qs, s);
						state_q <= ST_CALC;
						if (step_q == 5'd10) begin
							k0_q <= v; step_q <= 5'd11;
						end else begin
							k1_q <= v; step_q <= 5'd12;
						end
					end
				end
				default: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
			endcase
			sat_q <= s;
		end
	end

	property p_busy_not_ready;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ready;
	endproperty
	a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(filtered_angle)))
		else $error("output word dropped");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CALC && !out_valid))
		else $error("accept did not start sequencer");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman angle and bias filter testbench
// Drives tilt words through the valid/ready channels under random idling on
// both sides and checks every output word against a fixed-point filter model
// kept here or typed rows' values, across several noise register settings.
// ----------------------------------------------------------------------------
module testbench
	import kabf_pkg::*;
();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 400;
	localparam int DT_5MS = 1342177;

	typedef struct packed {
		logic        axis;
		logic [31:0] angle;
		logic [31:0] rate;
		logic [30:0] dt;
		logic        typed;
		logic [31:0] exp_angle;
		logic [31:0] exp_bias;
		logic        exp_sat;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] angle;
		logic [31:0] bias;
		logic        sat;
	} tilt_t;

	localparam int DIR_DEFAULT = 10;
	stim_row_t dir_rows [0:19] = '{
		'{1'b0, 32'h7fffffff, 32'h80000000, 31'd0, 1'b1, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h80000000, 32'h7fffffff, 31'd0, 1'b1, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h00000000, 32'h00000000, 31'd0, 1'b1, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h0a000000, 32'h00100000, DT_5MS[30:0], 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h0a000000, 32'h00100000, DT_5MS[30:0], 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'hf6000000, 32'hfff00000, DT_5MS[30:0], 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h80000000, 32'h80000000, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h00000000, 32'h00000000, 31'd1, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h05a00000, 32'h00000000, 31'h10000000, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h80000000, 32'h80000000, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h00000000, 32'h00000000, 31'd0, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h00000001, 32'hffffffff, 31'd1, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h05a00000, 32'h00000000, DT_5MS[30:0], 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'hfa600000, 32'h0fa00000, DT_5MS[30:0], 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b0, 32'h00100000, 32'h00000000, 31'h40000000, 1'b0, 32'd0, 32'd0, 1'b0},
		'{1'b1, 32'h00000000, 32'h80000000, 31'h00000100, 1'b0, 32'd0, 32'd0, 1'b0}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic             axis;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic [30:0]      time_step;
	logic             out_valid;
	logic             out_ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] rate_bias;
	logic             saturated;

	kalman_angle_bias_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .axis(axis),
		.measured_angle(measured_angle), .measured_rate(measured_rate),
		.time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered_angle(filtered_angle), .rate_bias(rate_bias), .saturated(saturated)
	);

	// Filter model state
	logic [CFG_W-1:0] noise_angle, noise_bias, noise_meas;
	int  est_angle [2];
	int  est_bias [2];
	int  p_aa [2], p_ab [2], p_ba [2], p_bb [2];
	bit  clipped;

	tilt_t expected_words [$];
	int  mismatches;
	int  cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  recv_hold;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int clip(longint v);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return 32'h80000000;
		end
		return int'(v);
	endfunction

	function automatic int mulq(longint a, longint b);
		return clip((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
	endfunction

	function automatic int divq(int num, int den);
		if (den == 0) begin
			clipped = 1'b1;
			return 0;
		end
		return clip((longint'(num) <<< FRAC) / longint'(den));
	endfunction

	function automatic tilt_t filter_step(logic ch, logic [31:0] ma, logic [31:0] mr,
			logic [30:0] dt_in);
		longint dt;
		int ang, bias, p00, p01, p10, p11, rate, inner, s, k0, k1, y, p00o, p01o;
		tilt_t r;
		clipped = 1'b0;
		dt = longint'(dt_in);
		ang = est_angle[ch];
		bias = est_bias[ch];
		p00 = p_aa[ch];
		p01 = p_ab[ch];
		p10 = p_ba[ch];
		p11 = p_bb[ch];
		rate = clip(longint'(signed'(mr)) - bias);
		ang = clip(longint'(ang) + mulq(dt, rate));
		inner = clip(longint'(mulq(dt, p11)) - p01 - p10 + longint'(noise_angle));
		p00 = clip(longint'(p00) + mulq(dt, inner));
		p01 = clip(longint'(p01) - mulq(dt, p11));
		p10 = clip(longint'(p10) - mulq(dt, p11));
		p11 = clip(longint'(p11) + mulq(longint'(noise_bias), dt));
		s = clip(longint'(p00) + longint'(noise_meas));
		k0 = divq(p00, s);
		k1 = divq(p10, s);
		y = clip(longint'(signed'(ma)) - ang);
		ang = clip(longint'(ang) + mulq(k0, y));
		bias = clip(longint'(bias) + mulq(k1, y));
		p00o = p00;
		p01o = p01;
		p00 = clip(longint'(p00) - mulq(k0, p00o));
		p01 = clip(longint'(p01) - mulq(k0, p01o));
		p10 = clip(longint'(p10) - mulq(k1, p00o));
		p11 = clip(longint'(p11) - mulq(k1, p01o));
		est_angle[ch] = ang;
		est_bias[ch] = bias;
		p_aa[ch] = p00;
		p_ab[ch] = p01;
		p_ba[ch] = p10;
		p_bb[ch] = p11;
		r.angle = ang;
		r.bias = bias;
		r.sat = clipped;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_Q_ANGLE: noise_angle = val;
			REG_Q_BIAS: noise_bias = val;
			default: noise_meas = (val == '0) ? 31'd1 : val;
		endcase
	endtask

	task automatic tune(logic [CFG_W-1:0] qa, logic [CFG_W-1:0] qb, logic [CFG_W-1:0] rm);
		write_reg(REG_Q_ANGLE, qa);
		write_reg(REG_Q_BIAS, qb);
		write_reg(REG_R_MEAS, rm);
	endtask

	task automatic drain();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_word(stim_row_t row);
		tilt_t prediction;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		axis <= row.axis;
		measured_angle <= row.angle;
		measured_rate <= row.rate;
		time_step <= row.dt;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		prediction = filter_step(row.axis, row.angle, row.rate, row.dt);
		if (row.typed) begin
			prediction.angle = row.exp_angle;
			prediction.bias = row.exp_bias;
			prediction.sat = row.exp_sat;
		end
		expected_words.push_back(prediction);
	endtask

	function automatic stim_row_t random_row();
		stim_row_t row;
		row = '0;
		row.axis = 1'($urandom_range(1));
		if ($urandom_range(99) < 15) begin
			row.angle = $urandom;
			row.rate = $urandom;
			row.dt = 31'($urandom);
		end else begin
			row.angle = $urandom_range(180 << 20) - (90 << 20);
			row.rate = $urandom_range(500 << 20) - (250 << 20);
			row.dt = 31'($urandom_range(4 * DT_5MS, DT_5MS / 4));
		end
		return row;
	endfunction

	task automatic random_phase();
		repeat (RANDOM_WORDS) send_word(random_row());
		@(posedge clk);
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(negedge clk) begin
		tilt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report("unexpected word, filtered_angle", filtered_angle, 32'd0);
			end else begin
				want = expected_words.pop_front();
				if (filtered_angle !== want.angle)
					report("filtered_angle", filtered_angle, want.angle);
				if (rate_bias !== want.bias)
					report("rate_bias", rate_bias, want.bias);
				if (saturated !== want.sat)
					report("saturated", {31'd0, saturated}, {31'd0, want.sat});
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** kalman_angle_bias_filter: FAILED **");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		axis = 1'b0;
		measured_angle = '0;
		measured_rate = '0;
		time_step = '0;
		out_ready = 1'b0;
		noise_angle = Q_ANGLE_RST;
		noise_bias = Q_BIAS_RST;
		noise_meas = R_MEAS_RST;
		for (int c = 0; c < 2; c++) begin
			est_angle[c] = 0;
			est_bias[c] = 0;
			p_aa[c] = 0;
			p_ab[c] = 0;
			p_ba[c] = 0;
			p_bb[c] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 20;
		for (int i = 0; i < 20; i++) begin
			if (i == DIR_DEFAULT) begin
				@(posedge clk);
				in_valid <= 1'b0;
				drain();
				tune(31'h7fffffff, 31'h7fffffff, 31'd0);
			end
			send_word(dir_rows[i]);
		end
		@(posedge clk);
		in_valid <= 1'b0;
		drain();

		tune(31'd0, 31'd0, 31'h7fffffff);
		send_idle_pct = 35;
		recv_idle_pct = 54;
		random_phase();
		drain();

		tune(31'($urandom_range(1000000)), 31'($urandom_range(2000000)),
			31'($urandom_range(20000000)));
		send_idle_pct = 54;
		recv_idle_pct = 35;
		random_phase();
		drain();

		tune(Q_ANGLE_RST, 31'd805306, R_MEAS_RST);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 3000;
		random_phase();
		drain();

		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("** kalman_angle_bias_filter: PASSED **");
		end else begin
			$display("** kalman_angle_bias_filter: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/kabf_pkg.sv
rtl/core/kalman_angle_bias_filter.sv
dv/testbench.sv
